@@ rtl/serial_command_frame_parser_defines.svh @@
// Assertion helpers for the frame parser.
`ifndef SERIAL_COMMAND_FRAME_PARSER_DEFINES_SVH
`define SERIAL_COMMAND_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SCFP_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
// next-cycle implication
`define SCFP_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`else
`define SCFP_ASSERT_IMPL(label, clk, rst, cond, prop, msg)
`define SCFP_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif

`endif

@@ rtl/scfp_pkg.sv @@
package scfp_pkg;

   localparam int LED_SLOTS  = 4;
   localparam int MASK_WIDTH = 4;

   localparam logic [7:0] BROADCAST_HEADER = 8'h80;
   localparam logic [6:0] NODE_ADDR_RESET  = 7'h27;
   localparam int         STROBE_BIT       = 6;

   // command codes
   localparam logic [6:0] CMD_PING     = 7'h01;
   localparam logic [6:0] CMD_STATUS_A = 7'h02;
   localparam logic [6:0] CMD_STATUS_B = 7'h03;
   localparam logic [6:0] CMD_LOAD     = 7'h41;
   localparam logic [6:0] CMD_STAGE    = 7'h61;

   localparam logic [7:0] REPLY_STATUS = 8'h01;

   // byte position codes
   localparam logic [2:0] POS_IDLE     = 3'd0;
   localparam logic [2:0] POS_COMMAND  = 3'd1;
   localparam logic [2:0] POS_PAYLOAD0 = 3'd2;
   localparam logic [2:0] POS_PAYLOAD1 = 3'd3;
   localparam logic [2:0] POS_PAYLOAD2 = 3'd4;

   // frame length codes (last position of frame)
   localparam logic [2:0] LEN_SHORT = 3'd1;
   localparam logic [2:0] LEN_ONE   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd4;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } colour_type;

   typedef struct packed {
      logic [7:0] header;
      logic [6:0] command;
      logic [7:0] pay0;
      logic [7:0] pay1;
      logic [7:0] pay2;
   } frame_type;

   typedef struct packed {
      logic                  valid;
      logic [7:0]            reply;
      logic [MASK_WIDTH-1:0] mask;
      logic [LED_SLOTS-1:0]  slot_sel;
      logic                  strobe;
      colour_type            colour;
   } exec_type;

endpackage

@@ rtl/serial_command_frame_parser.sv @@
// Serial command frame parser.
// Path: input register, then result register, from request accept to response
// valid. Throughput: one request per cycle while the response is not stalled.
// Reset: synchronous, active high; clears frame position, staged colour,
// LED slot colours and pipeline valids; node address returns to 0x27.
`include "serial_command_frame_parser_defines.svh"

module serial_command_frame_parser (
   input  logic        clock,
   input  logic        reset,
   // request: [7:0] rx_byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // response: [7:0] reply_byte, [11:8] slot_write_mask, [19:12] red_level,
   // [27:20] green_level, [35:28] blue_level, [36] refresh_strobe, [39:37] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // node address register
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   // node address
   logic [6:0] node_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff <= scfp_pkg::NODE_ADDR_RESET;
      end else if (csr_wr_en) begin
         node_ff <= csr_wr_data;
      end
   end

   // handshake: stage 2 moves whenever the response register is free or
   // being drained this cycle
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       out_free;
   logic       s2_fire;

   assign out_free   = !rsp_tvalid || rsp_tready;
   assign req_tready = !s1_valid_ff || out_free;
   assign s2_fire    = s1_valid_ff && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
      end
   end

   // frame collection state
   logic [2:0] pos_ff,    pos_in;
   logic [2:0] len_ff,    len_in;
   logic [7:0] header_ff, header_in;
   logic [6:0] cmd_ff,    cmd_in;
   logic [7:0] pay_ff [3];
   logic [7:0] pay_in [3];
   logic       complete;

   always_comb begin
      pos_in    = pos_ff;
      len_in    = len_ff;
      header_in = header_ff;
      cmd_in    = cmd_ff;
      pay_in    = pay_ff;
      complete  = 1'b0;
      if (s1_byte_ff[7]) begin
         // header restarts collection, partial frame dropped
         header_in = s1_byte_ff;
         pos_in    = scfp_pkg::POS_COMMAND;
      end else if (pos_ff == scfp_pkg::POS_IDLE) begin
         // stray data byte: discarded
         pos_in = scfp_pkg::POS_IDLE;
      end else if (pos_ff == scfp_pkg::POS_COMMAND) begin
         cmd_in = s1_byte_ff[6:0];
         if (!s1_byte_ff[6]) begin
            len_in   = scfp_pkg::LEN_SHORT;
            pos_in   = scfp_pkg::POS_IDLE;
            complete = 1'b1;
         end else begin
            len_in = s1_byte_ff[5] ? scfp_pkg::LEN_THREE : scfp_pkg::LEN_ONE;
            pos_in = scfp_pkg::POS_PAYLOAD0;
         end
      end else begin
         case (pos_ff)
            scfp_pkg::POS_PAYLOAD0: pay_in[0] = s1_byte_ff;
            scfp_pkg::POS_PAYLOAD1: pay_in[1] = s1_byte_ff;
            scfp_pkg::POS_PAYLOAD2: pay_in[2] = s1_byte_ff;
            default:                pay_in    = pay_ff;
         endcase
         if (pos_ff >= len_ff) begin
            pos_in   = scfp_pkg::POS_IDLE;
            complete = 1'b1;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= scfp_pkg::POS_IDLE;
         len_ff <= 3'd0;
      end else if (s2_fire) begin
         pos_ff <= pos_in;
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         header_ff <= header_in;
         cmd_ff    <= cmd_in;
         pay_ff    <= pay_in;
      end
   end

   // frame execution; the frame view already carries this byte
   scfp_pkg::frame_type  frame;
   scfp_pkg::colour_type staged_ff;
   scfp_pkg::exec_type   exec;
   logic                 run;

   assign frame.header  = header_ff;
   assign frame.command = cmd_in;
   assign frame.pay0    = pay_in[0];
   assign frame.pay1    = pay_in[1];
   assign frame.pay2    = pay_in[2];

   scfp_exec u_exec (
      .frame        (frame),
      .node_address (node_ff),
      .staged       (staged_ff),
      .result       (exec)
   );

   assign run = s2_fire && complete && exec.valid;

   // staged colour and LED slots
   scfp_pkg::colour_type slot_ff [scfp_pkg::LED_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         staged_ff <= '0;
         for (int k = 0; k < scfp_pkg::LED_SLOTS; k++) begin
            slot_ff[k] <= '0;
         end
      end else if (run) begin
         staged_ff <= exec.colour;
         for (int k = 0; k < scfp_pkg::LED_SLOTS; k++) begin
            if (exec.slot_sel[k]) begin
               slot_ff[k] <= staged_ff;
            end
         end
      end
   end

   // response register
   logic               rsp_valid_ff;
   scfp_pkg::exec_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= run;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         rsp_ff <= exec;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.strobe, rsp_ff.colour.blue, rsp_ff.colour.green,
                        rsp_ff.colour.red, rsp_ff.mask, rsp_ff.reply};

   // checks
   `SCFP_ASSERT_IMPL(a_pos_within_len, clock, reset, pos_ff > scfp_pkg::POS_COMMAND, (pos_ff <= len_ff) && (len_ff == scfp_pkg::LEN_ONE || len_ff == scfp_pkg::LEN_THREE), "payload position outside frame length")
   `SCFP_ASSERT_NEXT(a_stall_holds_stage, clock, reset, rsp_tvalid && !rsp_tready, $stable(staged_ff) && $stable(pos_ff), "state moved while response stalled")
   `SCFP_ASSERT_IMPL(a_load_reply, clock, reset, rsp_tvalid && (rsp_ff.mask != '0), rsp_ff.reply == {1'b0, node_ff}, "slot load without own-address reply")

endmodule

@@ rtl/scfp_exec.sv @@
// Executes one complete frame: address match, command decode, reply.
module scfp_exec (
   input  scfp_pkg::frame_type  frame,
   input  logic [6:0]           node_address,
   input  scfp_pkg::colour_type staged,
   output scfp_pkg::exec_type   result
);

   logic broadcast;
   logic mine;

   assign broadcast = (frame.header == scfp_pkg::BROADCAST_HEADER);
   assign mine      = (frame.header == {1'b1, node_address});

   always_comb begin
      result          = '0;
      result.reply    = {1'b0, node_address};
      result.colour   = staged;
      result.valid    = 1'b0;
      case (frame.command)
         scfp_pkg::CMD_PING: begin
            result.valid = mine && !broadcast;
         end
         scfp_pkg::CMD_STATUS_A, scfp_pkg::CMD_STATUS_B: begin
            result.valid = mine || broadcast;
            result.reply = scfp_pkg::REPLY_STATUS;
         end
         scfp_pkg::CMD_LOAD: begin
            result.valid  = mine || broadcast;
            result.strobe = frame.pay0[scfp_pkg::STROBE_BIT];
            for (int k = 0; k < scfp_pkg::LED_SLOTS; k++) begin
               result.slot_sel[k] = frame.pay0[k];
            end
            for (int k = 0; k < scfp_pkg::MASK_WIDTH; k++) begin
               result.mask[k] = (k < scfp_pkg::LED_SLOTS) ? frame.pay0[k] : 1'b0;
            end
         end
         scfp_pkg::CMD_STAGE: begin
            result.valid        = mine || broadcast;
            result.colour.red   = frame.pay0;
            result.colour.green = frame.pay1;
            result.colour.blue  = frame.pay2;
         end
         default: begin
            result.valid = 1'b0;
         end
      endcase
      // slot writes and staging only take effect on a matched frame
      if (!result.valid) begin
         result.slot_sel = '0;
         result.colour   = staged;
      end
   end

endmodule
